// ----- rtl/sdv_pkg.sv -----
package sdv_pkg;

  localparam int unsigned FracBitsDef  = 24;
  localparam int unsigned OutFracBits  = 14;

  localparam int unsigned FreqWidth    = 25;
  localparam int unsigned DampWidth    = 25;
  localparam int unsigned DecayWidth   = 24;
  localparam int unsigned VelWidth     = 25;
  localparam int unsigned CfgDataWidth = 25;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned AccWidth     = 32;
  localparam int unsigned SampleWidth  = 16;

  localparam logic [FreqWidth-1:0]  FreqReset  = 25'd5944168;
  localparam logic [DampWidth-1:0]  DampReset  = 25'd1290555;
  localparam logic [DecayWidth-1:0] DecayReset = 24'd16771782;

  localparam logic [CfgIdxWidth-1:0] CfgFreq  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgDamp  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgDecay = 2'd2;

  localparam logic KindTick    = 1'b0;
  localparam logic KindTrigger = 1'b1;

  localparam logic signed [AccWidth-1:0] SampleMax = 32'sd32767;
  localparam logic signed [AccWidth-1:0] SampleMin = -32'sd32768;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_FB   = 10'b00_0000_0010,
    ST_DB   = 10'b00_0000_0100,
    ST_HI   = 10'b00_0000_1000,
    ST_FH   = 10'b00_0001_0000,
    ST_BP   = 10'b00_0010_0000,
    ST_SH   = 10'b00_0100_0000,
    ST_EN   = 10'b00_1000_0000,
    ST_DN   = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic signed [AccWidth-1:0] a;
    logic signed [AccWidth-1:0] b;
  } mul_op_t;

endpackage

// ----- rtl/sdv_qmul.sv -----
module sdv_qmul import sdv_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                       clk_i,
  input  mul_op_t                    op_i,
  output logic signed [AccWidth-1:0] prod_o
);

  logic signed [2*AccWidth-1:0] full;
  logic signed [AccWidth-1:0]   prod_q;

  assign full = op_i.a * op_i.b;

  always_ff @(posedge clk_i) begin
    prod_q <= full[FRAC_BITS+AccWidth-1:FRAC_BITS];
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/svf_resonant_drum_voice.sv -----
// Percussion voice: a state-variable filter (low and band accumulators) excited by an
// impulse and scaled by a decaying envelope, all in signed fixed point with FRAC_BITS
// fraction bits. A trigger beat (kind 1) loads the impulse and restarts the envelope and
// returns nothing. A tick beat (kind 0) returns one 16-bit sample and keeps the input
// stalled from its acceptance until the sample is written, so no new beat is taken
// before the last tick is through, because its five products pass one at a time through a
// single registered 32x32 multiplier; the result sits in an output register, and a stalled
// output holds the voice in its last step until the sample is taken.
module svf_resonant_drum_voice import sdv_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxWidth-1:0]        cfg_index_i,
  input  logic [CfgDataWidth-1:0]       cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [VelWidth-1:0]           velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SampleWidth-1:0] sample_o
);

  localparam int unsigned OutShift = FRAC_BITS - OutFracBits;
  localparam logic [AccWidth-1:0] OneQ = AccWidth'(1) << FRAC_BITS;

  state_e state_q, state_d;

  logic [FreqWidth-1:0]  freq_q;
  logic [DampWidth-1:0]  damp_q;
  logic [DecayWidth-1:0] decay_q;

  logic signed [AccWidth-1:0] low_q, band_q, env_q, pend_q, high_q, shaped_q;
  logic signed [SampleWidth-1:0] sample_q;
  logic out_valid_q;

  mul_op_t mul_op;
  logic signed [AccWidth-1:0] prod;

  logic in_accept, out_accept;
  logic [AccWidth:0]   vel_ext, vel_clamp;
  logic [AccWidth+1:0] vel_x3;
  logic signed [AccWidth-1:0] high_calc, scaled;
  logic signed [SampleWidth-1:0] sample_sat;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_accept  = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q  <= FreqReset;
      damp_q  <= DampReset;
      decay_q <= DecayReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFreq:  freq_q  <= cfg_wdata_i[FreqWidth-1:0];
        CfgDamp:  damp_q  <= cfg_wdata_i[DampWidth-1:0];
        CfgDecay: decay_q <= cfg_wdata_i[DecayWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_op.a = AccWidth'(freq_q);
    mul_op.b = band_q;
    case (state_q)
      ST_DB: begin
        mul_op.a = AccWidth'(damp_q);
        mul_op.b = band_q;
      end
      ST_FH: begin
        mul_op.a = AccWidth'(freq_q);
        mul_op.b = high_q;
      end
      ST_SH: begin
        mul_op.a = band_q;
        mul_op.b = env_q;
      end
      ST_EN: begin
        mul_op.a = env_q;
        mul_op.b = AccWidth'(decay_q);
      end
      default: begin
        mul_op.a = AccWidth'(freq_q);
        mul_op.b = band_q;
      end
    endcase
  end

  sdv_qmul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_qmul (
    .clk_i (clk_i),
    .op_i  (mul_op),
    .prod_o(prod)
  );

  assign vel_ext   = (AccWidth+1)'(velocity_i);
  assign vel_clamp = (vel_ext > (AccWidth+1)'(OneQ)) ? (AccWidth+1)'(OneQ) : vel_ext;
  assign vel_x3    = (AccWidth+2)'(vel_clamp) + ((AccWidth+2)'(vel_clamp) << 1);

  assign high_calc = pend_q - low_q - prod;
  assign scaled    = shaped_q >>> OutShift;
  assign sample_sat = (scaled > SampleMax) ? SampleMax[SampleWidth-1:0] :
                      (scaled < SampleMin) ? SampleMin[SampleWidth-1:0] :
                      scaled[SampleWidth-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_accept && kind_i == KindTick) state_d = ST_FB;
      ST_FB:   state_d = ST_DB;
      ST_DB:   state_d = ST_HI;
      ST_HI:   state_d = ST_FH;
      ST_FH:   state_d = ST_BP;
      ST_BP:   state_d = ST_SH;
      ST_SH:   state_d = ST_EN;
      ST_EN:   state_d = ST_DN;
      ST_DN:   state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      low_q       <= '0;
      band_q      <= '0;
      env_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept && kind_i == KindTrigger) begin
            pend_q <= vel_x3[AccWidth:1];
            env_q  <= OneQ;
          end
        end
        ST_DB: low_q <= low_q + prod;
        ST_HI: pend_q <= '0;
        ST_BP: band_q <= band_q + prod;
        ST_DN: env_q <= prod;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_HI) begin
      high_q <= high_calc;
    end
    if (state_q == ST_EN) begin
      shaped_q <= prod;
    end
    if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
      sample_q <= sample_sat;
    end
  end

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && kind_i == KindTick) |=> (state_q == ST_FB))
    else $error("tick beat did not start the filter update");

  a_trigger_env: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && kind_i == KindTrigger) |=> (state_q == ST_IDLE && env_q == OneQ))
    else $error("trigger beat did not restart the envelope");

  a_impulse_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FH) |-> (pend_q == '0))
    else $error("impulse not cleared after use");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("sample raised outside the output step");

endmodule
